// ===== src/tab_pkg.sv =====
// Shared types and constants for the transformed aligned box unit.
`timescale 1ns / 1ps

package tab_pkg;

    localparam int COORD_W  = 32;
    localparam int NUM_AXES = 3;
    localparam int NUM_REGS = 6;
    localparam int CFG_DW   = 64;
    localparam int ADDR_W   = 6;
    localparam int REG_IDX_W = 3;
    localparam int BOX_W    = 2 * NUM_AXES * COORD_W;

    // Register indexes, one 64-bit register per half row
    localparam logic [REG_IDX_W-1:0] REG_ROW0_LO = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_HI = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_LO = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_HI = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_LO = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_HI = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One transform row: three coefficients and the translation
    typedef struct packed {
        coord_t trans;
        coord_t c2;
        coord_t c1;
        coord_t c0;
    } row_coef_t;

    // Load strobes for the pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } stage_en_t;

endpackage

// ===== src/tab_cfg_regs.sv =====
// APB register file holding the 3x4 transform coefficients.
`timescale 1ns / 1ps

module tab_cfg_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [tab_pkg::ADDR_W-1:0]              paddr,
    input  logic [tab_pkg::CFG_DW-1:0]              pwdata,
    output logic [tab_pkg::CFG_DW-1:0]              prdata,
    output logic                                    pready,
    output tab_pkg::row_coef_t                      row_coef [tab_pkg::NUM_AXES]
);
    import tab_pkg::*;

    localparam logic [CFG_DW-1:0] ONE = CFG_DW'(1) << FRAC_BITS;

    logic [CFG_DW-1:0]    cfg_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 idx_ok;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign idx_ok  = (reg_idx < REG_IDX_W'(NUM_REGS));
    assign wr_en   = psel && penable && pwrite && pready && idx_ok;

    // Write the addressed register; reset to the identity transform
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_LO] <= ONE;
            cfg_reg[REG_ROW0_HI] <= '0;
            cfg_reg[REG_ROW1_LO] <= ONE << COORD_W;
            cfg_reg[REG_ROW1_HI] <= '0;
            cfg_reg[REG_ROW2_LO] <= '0;
            cfg_reg[REG_ROW2_HI] <= ONE;
        end
        else if (wr_en)
        begin
            cfg_reg[reg_idx] <= pwdata;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = cfg_reg[reg_idx];
        end
    end

    // Split each row pair into coefficients and translation
    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            row_coef[r].c0    = cfg_reg[2*r][COORD_W-1:0];
            row_coef[r].c1    = cfg_reg[2*r][CFG_DW-1:COORD_W];
            row_coef[r].c2    = cfg_reg[2*r+1][COORD_W-1:0];
            row_coef[r].trans = cfg_reg[2*r+1][CFG_DW-1:COORD_W];
        end
    end

endmodule

// ===== src/tab_lane.sv =====
// One output axis lane: column products, per-column min/max, partial sums.
`timescale 1ns / 1ps

module tab_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  tab_pkg::stage_en_t                en,
    input  tab_pkg::coord_t                   box_min [tab_pkg::NUM_AXES],
    input  tab_pkg::coord_t                   box_max [tab_pkg::NUM_AXES],
    input  tab_pkg::row_coef_t                coef,
    output logic signed [65-FRAC_BITS:0]      sum_lo,
    output logic signed [65-FRAC_BITS:0]      sum_hi
);
    import tab_pkg::*;

    localparam int PW = 2 * COORD_W;
    localparam int SW = PW - FRAC_BITS;
    localparam int AW = SW + 2;

    logic signed [COORD_W-1:0] coef_col [NUM_AXES];

    logic signed [PW-1:0] prod_min_reg [NUM_AXES];
    logic signed [PW-1:0] prod_max_reg [NUM_AXES];

    logic signed [PW-1:0] shr_min [NUM_AXES];
    logic signed [PW-1:0] shr_max [NUM_AXES];
    logic signed [SW-1:0] lo_next [NUM_AXES];
    logic signed [SW-1:0] hi_next [NUM_AXES];
    logic signed [SW-1:0] lo_reg  [NUM_AXES];
    logic signed [SW-1:0] hi_reg  [NUM_AXES];

    logic signed [AW-1:0] lo_a_reg;
    logic signed [AW-1:0] lo_b_reg;
    logic signed [AW-1:0] hi_a_reg;
    logic signed [AW-1:0] hi_b_reg;

    assign coef_col[0] = coef.c0;
    assign coef_col[1] = coef.c1;
    assign coef_col[2] = coef.c2;

    // Stage 1: full-width products of each coefficient with both corners
    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                prod_min_reg[c] <= coef_col[c] * box_min[c];
                prod_max_reg[c] <= coef_col[c] * box_max[c];
            end
        end
    end

    // Stage 2: floor shift, then order the pair per column
    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            shr_min[c] = prod_min_reg[c] >>> FRAC_BITS;
            shr_max[c] = prod_max_reg[c] >>> FRAC_BITS;
            if (shr_min[c] <= shr_max[c])
            begin
                lo_next[c] = shr_min[c][SW-1:0];
                hi_next[c] = shr_max[c][SW-1:0];
            end
            else
            begin
                lo_next[c] = shr_max[c][SW-1:0];
                hi_next[c] = shr_min[c][SW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Stage 3: partial sums, translation folded into the second one
    always_ff @(posedge clk)
    begin
        if (en.ld3)
        begin
            lo_a_reg <= AW'(lo_reg[0]) + AW'(lo_reg[1]);
            lo_b_reg <= AW'(lo_reg[2]) + AW'(coef.trans);
            hi_a_reg <= AW'(hi_reg[0]) + AW'(hi_reg[1]);
            hi_b_reg <= AW'(hi_reg[2]) + AW'(coef.trans);
        end
    end

    // Final sum goes to the merge stage
    assign sum_lo = lo_a_reg + lo_b_reg;
    assign sum_hi = hi_a_reg + hi_b_reg;

endmodule

// ===== src/tab_merge.sv =====
// Merge stage: saturate the lane sums and register the result beat.
`timescale 1ns / 1ps

module tab_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  tab_pkg::stage_en_t                     en,
    input  logic signed [65-FRAC_BITS:0]           sum_lo [tab_pkg::NUM_AXES],
    input  logic signed [65-FRAC_BITS:0]           sum_hi [tab_pkg::NUM_AXES],
    output logic [tab_pkg::BOX_W-1:0]              box_out,
    output logic                                   sat_out
);
    import tab_pkg::*;

    localparam int AW = 2 * COORD_W - FRAC_BITS + 2;
    localparam logic signed [AW-1:0] SAT_MAX = AW'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [AW-1:0] SAT_MIN = AW'(64'shFFFF_FFFF_8000_0000);

    coord_t lo_next [NUM_AXES];
    coord_t hi_next [NUM_AXES];
    logic   sat_next;
    logic [BOX_W-1:0] box_next;
    logic [BOX_W-1:0] box_reg;
    logic             sat_reg;

    // Clamp every axis to 32 bits and flag any clamp
    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            if (sum_lo[r] > SAT_MAX)
            begin
                lo_next[r] = SAT_MAX[COORD_W-1:0];
                sat_next   = 1'b1;
            end
            else if (sum_lo[r] < SAT_MIN)
            begin
                lo_next[r] = SAT_MIN[COORD_W-1:0];
                sat_next   = 1'b1;
            end
            else
            begin
                lo_next[r] = sum_lo[r][COORD_W-1:0];
            end

            if (sum_hi[r] > SAT_MAX)
            begin
                hi_next[r] = SAT_MAX[COORD_W-1:0];
                sat_next   = 1'b1;
            end
            else if (sum_hi[r] < SAT_MIN)
            begin
                hi_next[r] = SAT_MIN[COORD_W-1:0];
                sat_next   = 1'b1;
            end
            else
            begin
                hi_next[r] = sum_hi[r][COORD_W-1:0];
            end
        end
    end

    // Pack mins in the low half, maxes in the high half
    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            box_next[r*COORD_W +: COORD_W]              = lo_next[r];
            box_next[(r+NUM_AXES)*COORD_W +: COORD_W]   = hi_next[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld4)
        begin
            box_reg <= box_next;
            sat_reg <= sat_next;
        end
    end

    assign box_out = box_reg;
    assign sat_out = sat_reg;

endmodule

// ===== src/transform_aligned_box_unit.sv =====
// Top level: stream handshake, valid pipeline, three row lanes and merge.
`timescale 1ns / 1ps

// Transforms an axis-aligned 3D box (signed Q16.16 corners) by a 3x4 affine
// matrix set over APB and returns the bounding box of the result, clamped to
// 32 bits, with a flag when any coordinate was clamped. One box is taken per
// clock cycle while the output is not stalled. Three lanes, one per output
// axis, each hold six 32x32 multipliers that set the four-stage depth
// (multiply, floor and order, partial sum, final sum with saturation). Every
// stage holds its own valid bit, so a stalled output only blocks input once
// the pipeline is full. Configure only while no box is in flight.
module transform_aligned_box_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, low first)
    input  logic [191:0] s_axis_tdata,
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [191:0] m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser
);
    import tab_pkg::*;

    localparam int AW = 2 * COORD_W - FRAC_BITS + 2;

    row_coef_t row_coef [NUM_AXES];
    coord_t    box_min  [NUM_AXES];
    coord_t    box_max  [NUM_AXES];
    logic signed [AW-1:0] sum_lo [NUM_AXES];
    logic signed [AW-1:0] sum_hi [NUM_AXES];
    stage_en_t en;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic sat_flag;

    tab_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .row_coef (row_coef)
    );

    // Unpack the input beat into corner coordinates
    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            box_min[c] = s_axis_tdata[c*COORD_W +: COORD_W];
            box_max[c] = s_axis_tdata[(c+NUM_AXES)*COORD_W +: COORD_W];
        end
    end

    // A stage may load when empty or when the stage after it moves on
    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.ld1 = rdy1 && s_axis_tvalid;
    assign en.ld2 = rdy2 && v1_reg;
    assign en.ld3 = rdy3 && v2_reg;
    assign en.ld4 = rdy4 && v3_reg;

    assign v1_next = rdy1 ? s_axis_tvalid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;
    assign v4_next = rdy4 ? v3_reg : v4_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // One lane per output axis
    for (genvar r = 0; r < NUM_AXES; r++)
    begin : g_lane
        tab_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .box_min (box_min),
            .box_max (box_max),
            .coef    (row_coef[r]),
            .sum_lo  (sum_lo[r]),
            .sum_hi  (sum_hi[r])
        );
    end

    tab_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .en      (en),
        .sum_lo  (sum_lo),
        .sum_hi  (sum_hi),
        .box_out (m_axis_tdata),
        .sat_out (sat_flag)
    );

    assign s_axis_tready   = rdy1;
    assign m_axis_tvalid   = v4_reg;
    assign m_axis_tuser[0] = sat_flag;

endmodule
